@@ rtl/dfude_pkg.sv @@
// Package for the DFU download request engine: request and result types,
// state and code enums, command bytes and flash region constants.
// Used by dfude_ctrl and dfu_download_request_engine.
`timescale 1ns / 1ps
`default_nettype none

package dfude_pkg;

  localparam int unsigned TRANSFER_SIZE_DEF = 1024;

  localparam int unsigned KB_W       = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FLEN_W     = 11;
  localparam int unsigned POLL_W     = 24;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SIZE = 2'd1;

  localparam logic [KB_W-1:0] BOOT_SIZE_RST  = 11'd8;
  localparam logic [KB_W-1:0] FLASH_SIZE_RST = 11'd128;

  localparam logic [7:0]        CMD_SET_ADDRESS = 8'h21;
  localparam logic [7:0]        CMD_ERASE_PAGE  = 8'h41;
  localparam logic [31:0]       FLASH_BASE      = 32'h0800_0000;
  localparam logic [POLL_W-1:0] BUSY_POLL_MS    = 24'd100;

  localparam logic [2:0] REPLY_LEN_NONE   = 3'd0;
  localparam logic [2:0] REPLY_LEN_STATUS = 3'd6;
  localparam logic [2:0] REPLY_LEN_STATE  = 3'd1;
  localparam logic [2:0] REPLY_LEN_CMDS   = 3'd3;

  typedef enum logic [3:0] {
    REQ_DETACH      = 4'd0,
    REQ_DNLOAD      = 4'd1,
    REQ_UPLOAD      = 4'd2,
    REQ_GETSTATUS   = 4'd3,
    REQ_CLRSTATUS   = 4'd4,
    REQ_GETSTATE    = 4'd5,
    REQ_ABORT       = 4'd6,
    REQ_STATUS_DONE = 4'd7
  } req_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd2,
    ST_DN_SYNC  = 4'd3,
    ST_DN_BUSY  = 4'd4,
    ST_DN_IDLE  = 4'd5,
    ST_MAN_SYNC = 4'd6,
    ST_MANIFEST = 4'd7,
    ST_UP_IDLE  = 4'd9,
    ST_ERROR    = 4'd10
  } dfu_state_e;

  typedef enum logic [1:0] {
    REPLY_NONE   = 2'd0,
    REPLY_STATUS = 2'd1,
    REPLY_STATE  = 2'd2,
    REPLY_CMDS   = 2'd3
  } reply_kind_e;

  typedef enum logic [1:0] {
    FOP_NONE    = 2'd0,
    FOP_ERASE   = 2'd1,
    FOP_PROGRAM = 2'd2
  } flash_op_e;

  typedef struct packed {
    req_kind_e   kind;
    logic [15:0] block_num;
    logic [15:0] data_len;
    logic [7:0]  cmd_byte;
    logic [31:0] cmd_addr;
  } req_t;

  typedef struct packed {
    logic              handled;
    reply_kind_e       reply_kind;
    logic [2:0]        reply_len;
    logic [7:0]        status_code;
    logic [POLL_W-1:0] poll_timeout;
    dfu_state_e        dfu_state_out;
    flash_op_e         flash_op;
    logic [31:0]       flash_addr;
    logic [FLEN_W-1:0] flash_len;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/dfu_download_request_engine.sv @@
// A request beat is captured in the input register, then decoded into the result register.
// One request per cycle unless the output stalls; the input register feeds a single decode
// pass that updates the DFU state and loads the result register in the same edge.
// A stalled result holds in the result register while one more request waits.
// Reset clears the state to dfuIDLE, pointer and header to zero, and sets the
// bootloader and flash sizes to 8 KiB and 128 KiB.
`timescale 1ns / 1ps
`default_nettype none

module dfu_download_request_engine
  import dfude_pkg::*;
#(
  parameter int unsigned TransferSize = TRANSFER_SIZE_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [KB_W-1:0]       cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // block_num[15:0], data_len[31:16], cmd_byte[39:32], cmd_addr[71:40]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[3:0]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // reply_len[2:0], status_code[10:3], poll_timeout[34:11], dfu_state_out[38:35],
  // flash_op[40:39], flash_addr[72:41], flash_len[83:73], zero fill[87:84]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // handled[0], reply_kind[2:1]
  output logic [OUT_USER_W-1:0]      m_axis_tuser
);

  logic [KB_W-1:0] boot_kb_q, flash_kb_q;
  logic            in_valid_q, out_valid_q;
  req_t            in_item_q;
  res_t            out_res_q, res;
  logic            s_fire, out_free, advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_kb_q  <= BOOT_SIZE_RST;
      flash_kb_q <= FLASH_SIZE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BOOT_SIZE:  boot_kb_q  <= cfg_data_i;
        CFG_FLASH_SIZE: flash_kb_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q.kind      <= req_kind_e'(s_axis_tuser);
      in_item_q.block_num <= s_axis_tdata[15:0];
      in_item_q.data_len  <= s_axis_tdata[31:16];
      in_item_q.cmd_byte  <= s_axis_tdata[39:32];
      in_item_q.cmd_addr  <= s_axis_tdata[71:40];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  dfude_ctrl #(
    .TransferSize(TransferSize)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .item_i     (in_item_q),
    .boot_kb_i  (boot_kb_q),
    .flash_kb_i (flash_kb_q),
    .res_o      (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {out_res_q.reply_kind, out_res_q.handled};
  assign m_axis_tdata  = {4'b0, out_res_q.flash_len, out_res_q.flash_addr,
                          out_res_q.flash_op, out_res_q.dfu_state_out,
                          out_res_q.poll_timeout, out_res_q.status_code,
                          out_res_q.reply_len};

`ifndef ASSERT_OFF
  a_flash_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.flash_op != FOP_NONE |->
      out_res_q.handled && out_res_q.reply_kind == REPLY_NONE &&
      out_res_q.dfu_state_out == ST_DN_IDLE)
    else $error("flash command outside a status-done result");

  a_poll_enters_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.poll_timeout != '0 |->
      out_res_q.dfu_state_out == ST_DN_BUSY && out_res_q.reply_kind == REPLY_STATUS)
    else $error("poll timeout without entering busy");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled while a stage is free");

  a_advance_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after advance");
`endif

endmodule

`default_nettype wire

@@ rtl/dfude_ctrl.sv @@
// DFU state machine with the address pointer and the latched download header.
// Decides the reply and flash command of one request; depends on dfude_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfude_ctrl
  import dfude_pkg::*;
#(
  parameter int unsigned TransferSize = TRANSFER_SIZE_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire req_t            item_i,
  input  wire logic [KB_W-1:0] boot_kb_i,
  input  wire logic [KB_W-1:0] flash_kb_i,
  output res_t                 res_o
);

  localparam int unsigned LenW = $clog2(TransferSize + 1);

  dfu_state_e        state_q, state_d;
  logic [31:0]       ptr_q, ptr_d;
  logic [15:0]       hblk_q, hblk_d;
  logic [LenW-1:0]   hlen_q, hlen_d;
  logic [7:0]        hcmd_q, hcmd_d;
  logic [31:0]       harg_q, harg_d;
  logic [31:0]       hoff_q, hoff_d;

  logic [32:0] region_lo, region_hi;
  logic [31:0] prog_base;
  logic        erase_ok, prog_ok;

  always_comb begin
    region_lo = {1'b0, FLASH_BASE} + 33'({boot_kb_i, 10'b0});
    region_hi = {1'b0, FLASH_BASE} + 33'({flash_kb_i, 10'b0});
    prog_base = ptr_q + hoff_q;
    erase_ok  = ({1'b0, harg_q} >= region_lo) &&
                ({1'b0, harg_q} + 33'(TransferSize) <= region_hi);
    prog_ok   = ({1'b0, prog_base} >= region_lo) &&
                ({1'b0, prog_base} + 33'(hlen_q) <= region_hi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      hblk_q  <= '0;
      hlen_q  <= '0;
      hcmd_q  <= '0;
      harg_q  <= '0;
      hoff_q  <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      hblk_q  <= hblk_d;
      hlen_q  <= hlen_d;
      hcmd_q  <= hcmd_d;
      harg_q  <= harg_d;
      hoff_q  <= hoff_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    hblk_d  = hblk_q;
    hlen_d  = hlen_q;
    hcmd_d  = hcmd_q;
    harg_d  = harg_q;
    hoff_d  = hoff_q;

    res_o              = '0;
    res_o.handled      = 1'b1;
    res_o.reply_kind   = REPLY_NONE;
    res_o.reply_len    = REPLY_LEN_NONE;
    res_o.flash_op     = FOP_NONE;

    if (fire_i) begin
      case (item_i.kind)
        REQ_DETACH: begin
          state_d = ST_MANIFEST;
        end
        REQ_DNLOAD: begin
          if (item_i.data_len == '0) begin
            state_d = ST_MAN_SYNC;
          end else begin
            hblk_d  = item_i.block_num;
            hlen_d  = (32'(item_i.data_len) > TransferSize) ?
                      LenW'(TransferSize) : LenW'(item_i.data_len);
            hcmd_d  = item_i.cmd_byte;
            harg_d  = item_i.cmd_addr;
            // The block offset is formed here so the status-done pass only adds.
            hoff_d  = 32'((32'(item_i.block_num) - 32'd2) * 32'(TransferSize));
            state_d = ST_DN_SYNC;
          end
        end
        REQ_UPLOAD: begin
          if (item_i.block_num == '0) begin
            state_d          = ST_UP_IDLE;
            res_o.reply_kind = REPLY_CMDS;
            res_o.reply_len  = REPLY_LEN_CMDS;
          end else begin
            state_d = ST_ERROR;
          end
        end
        REQ_GETSTATUS: begin
          if (state_q == ST_DN_SYNC) begin
            state_d            = ST_DN_BUSY;
            res_o.poll_timeout = BUSY_POLL_MS;
          end else if (state_q == ST_MAN_SYNC) begin
            state_d = ST_MANIFEST;
          end else if (state_q == ST_ERROR) begin
            res_o.status_code = 8'(ST_ERROR);
          end
          res_o.reply_kind = REPLY_STATUS;
          res_o.reply_len  = REPLY_LEN_STATUS;
        end
        REQ_CLRSTATUS: begin
          if (state_q == ST_ERROR) begin
            state_d = ST_IDLE;
          end
        end
        REQ_GETSTATE: begin
          res_o.reply_kind = REPLY_STATE;
          res_o.reply_len  = REPLY_LEN_STATE;
        end
        REQ_ABORT: begin
          state_d = ST_IDLE;
        end
        REQ_STATUS_DONE: begin
          if (state_q == ST_DN_BUSY) begin
            if (hblk_q == '0) begin
              if (hcmd_q == CMD_ERASE_PAGE) begin
                if (erase_ok) begin
                  res_o.flash_op   = FOP_ERASE;
                  res_o.flash_addr = harg_q;
                end
              end else if (hcmd_q == CMD_SET_ADDRESS) begin
                ptr_d = harg_q;
              end
            end else if (prog_ok) begin
              res_o.flash_op   = FOP_PROGRAM;
              res_o.flash_addr = prog_base;
              res_o.flash_len  = FLEN_W'(hlen_q);
            end
            state_d = ST_DN_IDLE;
          end
        end
        default: begin
          res_o.handled = 1'b0;
        end
      endcase
    end

    res_o.dfu_state_out = state_d;
  end

endmodule

`default_nettype wire
